/* hdl/kct_pkg.sv */
package kct_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_BITS    = 16;
   localparam int COUNT_BITS  = 32;
   localparam int SLOT_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_REMOVE,
      KIND_LOOKUP,
      KIND_IGNORE
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_IGNORED   = 2'd1,
      ST_FULL      = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MATCH,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      kind_type              kind;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] amount;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     not_empty;
      item_type item;
   } head_type;

endpackage

/* hdl/kct_front.sv */
module kct_front (
   input  logic                          start,
   input  logic                          queue_full,
   input  logic [1:0]                    req_opcode,
   input  logic [kct_pkg::KEY_BITS-1:0]  req_tag_key,
   input  logic [kct_pkg::COUNT_BITS-1:0] req_amount,
   output logic                          busy,
   output kct_pkg::push_type             push
);
   import kct_pkg::*;

   kind_type kind;

   always_comb begin
      unique case (req_opcode)
         OP_ADD:    kind = KIND_ADD;
         OP_REMOVE: kind = KIND_REMOVE;
         OP_LOOKUP: kind = KIND_LOOKUP;
         default:   kind = KIND_LOOKUP;
      endcase
      if ((kind == KIND_ADD || kind == KIND_REMOVE) &&
          (req_tag_key == '0 || req_amount == '0)) begin
         kind = KIND_IGNORE;
      end
   end

   assign busy           = queue_full;
   assign push.push      = start && !queue_full;
   assign push.item.kind = kind;
   assign push.item.key  = req_tag_key;
   assign push.item.amount = req_amount;

endmodule

/* hdl/kct_queue.sv */
module kct_queue (
   input  logic              clock,
   input  logic              reset,
   input  kct_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output kct_pkg::head_type head
);
   import kct_pkg::*;

   item_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_pop;

   assign do_pop = pop && (count_ff != '0);
   assign full   = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head.not_empty = (count_ff != '0);
   assign head.item      = slot_ff[rd_ptr_ff];

endmodule

/* hdl/kct_back.sv */
module kct_back (
   input  logic                           clock,
   input  logic                           reset,
   input  kct_pkg::head_type              head,
   output logic                           pop,
   output logic                           rsp_valid,
   output logic [kct_pkg::COUNT_BITS-1:0] rsp_count_after,
   output logic                           rsp_key_present,
   output logic                           rsp_changed,
   output logic [1:0]                     rsp_status
);
   import kct_pkg::*;

   back_state_type state_ff, state_in;
   item_type       item_ff;

   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [COUNT_BITS-1:0] count_ff [ENTRIES];

   logic                  hit, free_ok;
   logic [SLOT_BITS-1:0]  hit_slot, free_slot;
   logic                  hit_ff, free_ok_ff;
   logic [SLOT_BITS-1:0]  hit_slot_ff, free_slot_ff;
   logic [COUNT_BITS-1:0] old_ff;

   logic                  exec;
   logic [COUNT_BITS:0]   sum;
   logic [COUNT_BITS-1:0] new_count;
   logic                  write_count, write_new, clear_valid;
   logic [COUNT_BITS-1:0] out_count;
   logic                  out_present, out_changed;
   status_type            out_status;

   logic                  rsp_valid_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_present_ff, rsp_changed_ff;
   status_type            rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (head.not_empty) state_in = BK_MATCH;
         BK_MATCH: state_in = BK_EXEC;
         BK_EXEC:  state_in = head.not_empty ? BK_MATCH : BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop  = 1'b0;
      exec = 1'b0;
      unique case (state_ff)
         BK_IDLE:  pop = head.not_empty;
         BK_MATCH: pop = 1'b0;
         BK_EXEC: begin
            pop  = head.not_empty;
            exec = 1'b1;
         end
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head.item;
      end
   end

   // The lowest valid slot with an equal key wins; key zero is never stored.
   always_comb begin
      hit       = 1'b0;
      hit_slot  = '0;
      free_ok   = 1'b0;
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == item_ff.key) begin
            hit      = 1'b1;
            hit_slot = SLOT_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_ok   = 1'b1;
            free_slot = SLOT_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_MATCH) begin
         hit_ff       <= hit;
         hit_slot_ff  <= hit_slot;
         free_ok_ff   <= free_ok;
         free_slot_ff <= free_slot;
         old_ff       <= count_ff[hit_slot];
      end
   end

   always_comb begin
      sum         = {1'b0, old_ff} + {1'b0, item_ff.amount};
      new_count   = old_ff;
      write_count = 1'b0;
      write_new   = 1'b0;
      clear_valid = 1'b0;
      out_count   = '0;
      out_present = 1'b0;
      out_changed = 1'b0;
      out_status  = ST_OK;
      unique case (item_ff.kind)
         KIND_IGNORE: begin
            out_status  = ST_IGNORED;
            out_present = hit_ff;
            out_count   = hit_ff ? old_ff : '0;
         end
         KIND_ADD: begin
            if (hit_ff) begin
               if (sum[COUNT_BITS]) begin
                  new_count  = '1;
                  out_status = ST_SATURATED;
               end else begin
                  new_count = sum[COUNT_BITS-1:0];
               end
               write_count = 1'b1;
               out_count   = new_count;
               out_present = 1'b1;
               out_changed = (new_count != old_ff);
            end else if (free_ok_ff) begin
               write_new   = 1'b1;
               out_count   = item_ff.amount;
               out_present = 1'b1;
               out_changed = 1'b1;
            end else begin
               out_status = ST_FULL;
            end
         end
         KIND_REMOVE: begin
            if (hit_ff) begin
               out_changed = 1'b1;
               if (old_ff <= item_ff.amount) begin
                  clear_valid = 1'b1;
               end else begin
                  new_count   = old_ff - item_ff.amount;
                  write_count = 1'b1;
                  out_count   = new_count;
                  out_present = 1'b1;
               end
            end
         end
         KIND_LOOKUP: begin
            out_present = hit_ff;
            out_count   = hit_ff ? old_ff : '0;
         end
         default: out_status = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (exec) begin
         if (write_new) begin
            valid_ff[free_slot_ff] <= 1'b1;
         end else if (clear_valid) begin
            valid_ff[hit_slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         if (write_new) begin
            key_ff[free_slot_ff]   <= item_ff.key;
            count_ff[free_slot_ff] <= item_ff.amount;
         end else if (write_count) begin
            count_ff[hit_slot_ff] <= new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_count_ff   <= out_count;
         rsp_present_ff <= out_present;
         rsp_changed_ff <= out_changed;
         rsp_status_ff  <= out_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_key_present = rsp_present_ff;
   assign rsp_changed     = rsp_changed_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

/* hdl/keyed_counter_table.sv */
// Associative table of key/count pairs with add, remove and lookup requests.
// A request beat is taken when start is high and busy is low, and lands in a
// two-entry queue; busy is high only while that queue is full. The back end
// takes each request through a match state, for the parallel key match over
// all table slots, and then an exec state, for the read-modify-write of the
// matched or free slot; a waiting request is popped in the exec state of the
// current one, and the result is registered out of the exec state. Each result
// beat is shown for exactly one cycle with rsp_valid high and cannot be held
// off. Only valid marks are cleared at reset, so the table is usable at once.
module keyed_counter_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_opcode,
   input  logic [kct_pkg::KEY_BITS-1:0]   req_tag_key,
   input  logic [kct_pkg::COUNT_BITS-1:0] req_amount,
   output logic                           rsp_valid,
   output logic [kct_pkg::COUNT_BITS-1:0] rsp_count_after,
   output logic                           rsp_key_present,
   output logic                           rsp_changed,
   output logic [1:0]                     rsp_status
);
   import kct_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   kct_front u_front (
      .start       (start),
      .queue_full  (queue_full),
      .req_opcode  (req_opcode),
      .req_tag_key (req_tag_key),
      .req_amount  (req_amount),
      .busy        (busy),
      .push        (push)
   );

   kct_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   kct_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_count_after (rsp_count_after),
      .rsp_key_present (rsp_key_present),
      .rsp_changed     (rsp_changed),
      .rsp_status      (rsp_status)
   );

endmodule
